[sv/oled_page_transpose_streamer_macros.svh]
// assertion macros used by the checker file
`ifndef OLED_PAGE_TRANSPOSE_STREAMER_MACROS_SVH
`define OLED_PAGE_TRANSPOSE_STREAMER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define OPTS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define OPTS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/opts_pkg.sv]
// shared types and constants of the page transpose streamer
package opts_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_COMMIT = 2'd1,
		OP_FETCH  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam int PAGE_BYTES = 128;
	localparam int ROW_BYTES  = 16;
	localparam logic [7:0] CONTROL_BYTE = 8'h40;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-3:0] REG_TRANSPOSE_ENABLE = '0;

endpackage

[sv/oled_page_transpose_streamer.sv]
// top level of the page transpose streamer: frame ram, stream sequencer, register port
//
// The block keeps a row-major monochrome frame (16 bytes per row, msb is the
// leftmost pixel, 8 rows per page, NUM_PAGE_ROWS pages) in one single-port
// synchronous ram and turns it into a display stream of packets: a 0x40
// control byte followed by PACKET_BYTES data bytes. An item is accepted at a
// clock edge where start is high and busy is low. Writes, commits, fetches of
// a control byte, fetches while idle and the unused opcode keep busy low:
// the result strobe (done) rises in the cycle after the accept, so one of
// these items can be taken every cycle. A data byte fetch raises busy: with
// transpose_enable set, the byte gathers one bit from each of the eight row
// bytes of its page, read one per cycle through the single ram port in
// ST_READ, then ST_FIN registers the result, and the next item can be taken
// in the cycle the result appears; with transpose_enable clear, one read is
// enough and ST_FIN registers the result from it. Each result is on the
// outputs for exactly one cycle and cannot be stalled by the receiver. Frame
// writes while sending are dropped, as are writes to addresses beyond the
// frame. There is no clearing pass: frame bytes hold whatever was last
// written, and unwritten bytes are undefined.
module oled_page_transpose_streamer #(
	parameter int NUM_PAGE_ROWS = 4,
	parameter int PACKET_BYTES  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item channel
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        op,
	input  logic [8:0]                        addr,
	input  logic [7:0]                        wdata,
	// result channel
	output logic                              done,
	output logic [7:0]                        stream_byte,
	output logic                              packet_start,
	output logic                              packet_end,
	output logic                              frame_done,
	output logic                              busy_res,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [opts_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [opts_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [opts_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	import opts_pkg::*;

	localparam int FRAME_BYTES = NUM_PAGE_ROWS * PAGE_BYTES;
	localparam int AW          = $clog2(FRAME_BYTES);
	localparam int PPW         = $clog2(PACKET_BYTES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [2:0]        row_q;        // next row of the page to read
	logic [7:0]        acc_q;        // gathered page bits, shifted in from the top
	logic              mode_q;       // transpose setting taken at the fetch
	logic [AW-1:0]     pos_q;        // data byte position in the frame
	logic [PPW-1:0]    pkt_q;        // data bytes sent in the current packet
	logic              ctl_due_q;
	logic              sending_q;
	logic              te_q;         // transpose_enable register

	logic              done_q;
	logic [7:0]        byte_q;
	logic              pstart_q;
	logic              pend_q;
	logic              fdone_q;
	logic              bres_q;

	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [7:0]        ram_rdata;

	logic              accept;
	logic              acc_write;
	logic              data_fetch;
	logic [AW-1:0]     page_base;
	logic [AW-1:0]     first_addr;
	logic [AW-1:0]     row_addr;
	logic              pix_bit;
	logic [7:0]        data_byte;
	logic              last_frame;
	logic              last_pkt;
	logic              cfg_wr;

	assign accept     = start && !busy;
	assign busy       = (state_q != ST_IDLE);
	assign data_fetch = (op_t'(op) == OP_FETCH) && sending_q && !ctl_due_q;
	assign acc_write  = accept && (op_t'(op) == OP_WRITE) && !sending_q
		&& (int'(addr) < FRAME_BYTES);

	// page byte i: column group i/8 of each row, bit 7-(i%8) of the row byte
	assign page_base  = pos_q & ~AW'(PAGE_BYTES - 1);
	assign row_addr   = page_base | AW'({row_q, pos_q[6:3]});
	assign first_addr = te_q ? (page_base | AW'({3'd0, pos_q[6:3]})) : pos_q;

	// single ram port: writes and first read while idle, row reads while busy
	always_comb begin
		ram_we   = acc_write;
		ram_addr = row_addr;
		if (state_q == ST_IDLE) begin
			ram_addr = acc_write ? AW'(addr) : first_addr;
		end
	end

	opts_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (ram_rdata)
	);

	assign pix_bit    = ram_rdata[~pos_q[2:0]];
	assign data_byte  = mode_q ? {pix_bit, acc_q[7:1]} : ram_rdata;
	assign last_frame = (pos_q == AW'(FRAME_BYTES - 1));
	assign last_pkt   = (pkt_q == PPW'(PACKET_BYTES - 1));

	// stream sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_q     <= '0;
			acc_q     <= '0;
			mode_q    <= 1'b1;
			pos_q     <= '0;
			pkt_q     <= '0;
			ctl_due_q <= 1'b1;
			sending_q <= 1'b0;
			done_q    <= 1'b0;
			byte_q    <= '0;
			pstart_q  <= 1'b0;
			pend_q    <= 1'b0;
			fdone_q   <= 1'b0;
			bres_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						byte_q   <= '0;
						pstart_q <= 1'b0;
						pend_q   <= 1'b0;
						fdone_q  <= 1'b0;
						bres_q   <= sending_q;
						done_q   <= 1'b1;
						unique case (op_t'(op))
							OP_WRITE, OP_NOP: begin
							end
							OP_COMMIT: begin
								if (!sending_q) begin
									sending_q <= 1'b1;
									pos_q     <= '0;
									pkt_q     <= '0;
									ctl_due_q <= 1'b1;
									bres_q    <= 1'b1;
								end
							end
							OP_FETCH: begin
								if (sending_q && ctl_due_q) begin
									byte_q    <= CONTROL_BYTE;
									pstart_q  <= 1'b1;
									ctl_due_q <= 1'b0;
									pkt_q     <= '0;
								end else if (data_fetch) begin
									// first read issued this cycle
									done_q <= 1'b0;
									mode_q <= te_q;
									row_q  <= 3'd1;
									state_q <= te_q ? ST_READ : ST_FIN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					acc_q <= {pix_bit, acc_q[7:1]};
					row_q <= row_q + 3'd1;
					if (row_q == 3'd7) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q  <= ST_IDLE;
					done_q   <= 1'b1;
					byte_q   <= data_byte;
					pstart_q <= 1'b0;
					pend_q   <= last_frame || last_pkt;
					fdone_q  <= last_frame;
					if (last_frame) begin
						sending_q <= 1'b0;
						pos_q     <= '0;
						pkt_q     <= '0;
						ctl_due_q <= 1'b1;
						bres_q    <= 1'b0;
					end else begin
						pos_q  <= pos_q + AW'(1);
						bres_q <= 1'b1;
						if (last_pkt) begin
							pkt_q     <= '0;
							ctl_due_q <= 1'b1;
						end else begin
							pkt_q <= pkt_q + PPW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// register port: one register in word 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[CFG_ADDR_W-1:2] == REG_TRANSPOSE_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			te_q <= 1'b1;
		end else if (cfg_wr) begin
			te_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TRANSPOSE_ENABLE)
		? {{(CFG_DATA_W-1){1'b0}}, te_q} : '0;

	assign done         = done_q;
	assign stream_byte  = byte_q;
	assign packet_start = pstart_q;
	assign packet_end   = pend_q;
	assign frame_done   = fdone_q;
	assign busy_res     = bres_q;

endmodule

[sv/opts_ram.sv]
// generic single-port ram with registered read
module opts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

[sv/opts_checker.sv]
// port-level checks of the page transpose streamer and their binding
`include "oled_page_transpose_streamer_macros.svh"

module opts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] stream_byte,
	input logic       packet_start,
	input logic       packet_end,
	input logic       frame_done,
	input logic       busy_res
);

	import opts_pkg::*;

	// an accepted item either finishes next cycle or holds the block busy
	`OPTS_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted item stalled")

	// no result strobe while a data fetch is still reading
	`OPTS_ASSERT_NOW(a_no_done_busy, busy, !done, "result while busy")

	// a data fetch ends with its result
	`OPTS_ASSERT_NOW(a_fetch_result, $fell(busy), done, "fetch ended without result")

	// last byte of the frame closes the packet and goes idle
	`OPTS_ASSERT_NOW(a_frame_end, done && frame_done, packet_end && !busy_res, "bad frame end")

	// a control byte is 0x40 and sending continues
	`OPTS_ASSERT_NOW(a_ctl_byte, done && packet_start,
		stream_byte == CONTROL_BYTE && busy_res && !packet_end, "bad control byte")

endmodule

bind oled_page_transpose_streamer opts_checker u_opts_checker (.*);
